// ===== hw/rtl/md5_pkg.sv =====
package md5_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRIME,
		S_ROUND,
		S_FOLD,
		S_EMIT
	} md5_state_t;

	typedef logic [31:0] word_t;

	localparam word_t IV_A = 32'h67452301;
	localparam word_t IV_B = 32'hEFCDAB89;
	localparam word_t IV_C = 32'h98BADCFE;
	localparam word_t IV_D = 32'h10325476;
	localparam word_t PAD_BYTE = 32'h00000080;
	localparam logic [5:0] LEN_SPLIT = 6'd56;
	localparam logic [3:0] LEN_LO_IDX = 4'd14;
	localparam logic [3:0] LEN_HI_IDX = 4'd15;

	function automatic word_t md5_sine(input logic [5:0] k);
		word_t v;
		unique case (k)
			6'd0: v = 32'hd76aa478; 6'd1: v = 32'he8c7b756;
			6'd2: v = 32'h242070db; 6'd3: v = 32'hc1bdceee;
			6'd4: v = 32'hf57c0faf; 6'd5: v = 32'h4787c62a;
			6'd6: v = 32'ha8304613; 6'd7: v = 32'hfd469501;
			6'd8: v = 32'h698098d8; 6'd9: v = 32'h8b44f7af;
			6'd10: v = 32'hffff5bb1; 6'd11: v = 32'h895cd7be;
			6'd12: v = 32'h6b901122; 6'd13: v = 32'hfd987193;
			6'd14: v = 32'ha679438e; 6'd15: v = 32'h49b40821;
			6'd16: v = 32'hf61e2562; 6'd17: v = 32'hc040b340;
			6'd18: v = 32'h265e5a51; 6'd19: v = 32'he9b6c7aa;
			6'd20: v = 32'hd62f105d; 6'd21: v = 32'h02441453;
			6'd22: v = 32'hd8a1e681; 6'd23: v = 32'he7d3fbc8;
			6'd24: v = 32'h21e1cde6; 6'd25: v = 32'hc33707d6;
			6'd26: v = 32'hf4d50d87; 6'd27: v = 32'h455a14ed;
			6'd28: v = 32'ha9e3e905; 6'd29: v = 32'hfcefa3f8;
			6'd30: v = 32'h676f02d9; 6'd31: v = 32'h8d2a4c8a;
			6'd32: v = 32'hfffa3942; 6'd33: v = 32'h8771f681;
			6'd34: v = 32'h6d9d6122; 6'd35: v = 32'hfde5380c;
			6'd36: v = 32'ha4beea44; 6'd37: v = 32'h4bdecfa9;
			6'd38: v = 32'hf6bb4b60; 6'd39: v = 32'hbebfbc70;
			6'd40: v = 32'h289b7ec6; 6'd41: v = 32'heaa127fa;
			6'd42: v = 32'hd4ef3085; 6'd43: v = 32'h04881d05;
			6'd44: v = 32'hd9d4d039; 6'd45: v = 32'he6db99e5;
			6'd46: v = 32'h1fa27cf8; 6'd47: v = 32'hc4ac5665;
			6'd48: v = 32'hf4292244; 6'd49: v = 32'h432aff97;
			6'd50: v = 32'hab9423a7; 6'd51: v = 32'hfc93a039;
			6'd52: v = 32'h655b59c3; 6'd53: v = 32'h8f0ccc92;
			6'd54: v = 32'hffeff47d; 6'd55: v = 32'h85845dd1;
			6'd56: v = 32'h6fa87e4f; 6'd57: v = 32'hfe2ce6e0;
			6'd58: v = 32'ha3014314; 6'd59: v = 32'h4e0811a1;
			6'd60: v = 32'hf7537e82; 6'd61: v = 32'hbd3af235;
			6'd62: v = 32'h2ad7d2bb; 6'd63: v = 32'heb86d391;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	function automatic logic [4:0] md5_shift(input logic [5:0] k);
		logic [4:0] s;
		unique case ({k[5:4], k[1:0]})
			4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
			4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
			4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] md5_index(input logic [5:0] k);
		logic [3:0] g;
		logic [3:0] kl;
		kl = k[3:0];
		unique case (k[5:4])
			2'd0: g = kl;
			2'd1: g = 4'(kl * 4'd5 + 4'd1);
			2'd2: g = 4'(kl * 4'd3 + 4'd5);
			2'd3: g = 4'(kl * 4'd7);
			default: g = kl;
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/md5_buf_ram.sv =====
module md5_buf_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);
	import md5_pkg::*;

	word_t mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/md5_round.sv =====
module md5_round (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] m,
	input  logic [5:0]  k,
	output logic [31:0] b_new
);
	import md5_pkg::*;

	word_t f;
	word_t x;
	logic [4:0] s;

	always_comb begin
		unique case (k[5:4])
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			2'd3: f = c ^ (b | ~d);
			default: f = b;
		endcase
		x = a + f + md5_sine(k) + m;
		s = md5_shift(k);
		b_new = b + ((x << s) | (x >> (6'd32 - {1'b0, s})));
	end

endmodule

// ===== hw/rtl/md5_digest_engine.sv =====
// MD5 digest engine.
// Input channel: in_valid/in_stall with byte_value, byte_present and
// end_of_message. Bytes are packed little-endian into a 16-word buffer RAM.
// A byte that does not complete a 64-byte block is taken without a stall. A
// byte that completes a block starts a compression (a RAM prime step, 64
// rounds at one round per cycle, a fold step); in_stall stays high during it,
// so the engine takes no new byte while a block is being compressed.
// An end transaction pads the message and runs one final compression, or two
// when the tail holds 56 to 63 bytes, then presents four result transactions
// on out_valid/out_stall: digest words A, B, C, D with word_number 0 to 3 and
// last_word on the fourth. The input stays stalled until the fourth digest
// word is taken; while out_stall is high the current word holds.
// After the digest the engine returns to the initial chaining value for the
// next message. Reset (arst_n low) restores the initial chaining value and a
// zero byte count; it needs no clearing pass.
module md5_digest_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_number,
	output logic        last_word
);
	import md5_pkg::*;

	md5_state_t state_q, state_d;
	logic [60:0] cnt_q, cnt_inc;
	word_t word_q, nw, padw_new, cur_word;
	word_t cv_q [4];
	word_t a_q, b_q, c_q, d_q, m, b_new, rdata, mask;
	logic [5:0] rnd_q, pos_new;
	logic pend_q, pad_q, len_q, blank_q, two_q;
	logic [3:0] padidx_q, padidx_new, raddr, g_cur;
	word_t padw_q;
	logic [1:0] widx_q;
	logic acc, we;
	logic [63:0] bits;

	assign acc = in_valid && !in_stall;
	assign cnt_inc = cnt_q + 61'd1;
	assign bits = {cnt_q, 3'b000};
	assign g_cur = md5_index(rnd_q);

	always_comb begin
		nw = word_q;
		nw[8 * cnt_q[1:0] +: 8] = byte_value;
		pos_new = byte_present ? cnt_inc[5:0] : cnt_q[5:0];
		cur_word = byte_present ? nw : word_q;
		mask = (32'h1 << (8 * pos_new[1:0])) - 32'h1;
		padw_new = (cur_word & mask) | (PAD_BYTE << (8 * pos_new[1:0]));
		padidx_new = pos_new[5:2];
	end

	assign we = acc && byte_present && (cnt_q[1:0] == 2'd3);

	always_comb begin
		unique case (state_q)
			S_PRIME: raddr = md5_index(6'd0);
			S_ROUND: raddr = md5_index(6'(rnd_q + 6'd1));
			default: raddr = 4'd0;
		endcase
	end

	md5_buf_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[5:2]),
		.wdata (nw),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		priority if (len_q && g_cur == LEN_LO_IDX) begin
			m = bits[31:0];
		end else if (len_q && g_cur == LEN_HI_IDX) begin
			m = bits[63:32];
		end else if (blank_q) begin
			m = '0;
		end else if (pad_q && g_cur == padidx_q) begin
			m = padw_q;
		end else if (pad_q && g_cur > padidx_q) begin
			m = '0;
		end else begin
			m = rdata;
		end
	end

	md5_round u_round (
		.a     (a_q),
		.b     (b_q),
		.c     (c_q),
		.d     (d_q),
		.m     (m),
		.k     (rnd_q),
		.b_new (b_new)
	);

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (acc && ((byte_present && cnt_inc[5:0] == 6'd0) || end_of_message)) begin
					state_d = S_PRIME;
				end
			end
			S_PRIME: state_d = S_ROUND;
			S_ROUND: if (rnd_q == 6'd63) state_d = S_FOLD;
			S_FOLD: begin
				priority if (two_q) begin
					state_d = S_PRIME;
				end else if (len_q) begin
					state_d = S_EMIT;
				end else if (pend_q) begin
					state_d = S_PRIME;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall && widx_q == 2'd3) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign digest_word = cv_q[widx_q];
	assign word_number = widx_q;
	assign last_word = (widx_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			cv_q[0] <= IV_A;
			cv_q[1] <= IV_B;
			cv_q[2] <= IV_C;
			cv_q[3] <= IV_D;
			rnd_q <= '0;
			pend_q <= 1'b0;
			pad_q <= 1'b0;
			len_q <= 1'b0;
			blank_q <= 1'b0;
			two_q <= 1'b0;
			widx_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (byte_present) begin
							cnt_q <= cnt_inc;
						end
						if (byte_present && cnt_inc[5:0] == 6'd0) begin
							pad_q <= 1'b0;
							len_q <= 1'b0;
							blank_q <= 1'b0;
							two_q <= 1'b0;
							pend_q <= end_of_message;
						end else if (end_of_message) begin
							pad_q <= 1'b1;
							blank_q <= 1'b0;
							len_q <= (pos_new < LEN_SPLIT);
							two_q <= (pos_new >= LEN_SPLIT);
							pend_q <= 1'b0;
						end
					end
				end
				S_PRIME: rnd_q <= '0;
				S_ROUND: rnd_q <= rnd_q + 6'd1;
				S_FOLD: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
					priority if (two_q) begin
						two_q <= 1'b0;
						blank_q <= 1'b1;
						len_q <= 1'b1;
						pad_q <= 1'b0;
					end else if (len_q) begin
						widx_q <= '0;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						pad_q <= 1'b1;
						blank_q <= 1'b0;
						len_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (!out_stall) begin
						widx_q <= widx_q + 2'd1;
						if (widx_q == 2'd3) begin
							cv_q[0] <= IV_A;
							cv_q[1] <= IV_B;
							cv_q[2] <= IV_C;
							cv_q[3] <= IV_D;
							cnt_q <= '0;
							len_q <= 1'b0;
							pad_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc) begin
			if (byte_present) begin
				word_q <= nw;
			end
			padw_q <= padw_new;
			padidx_q <= padidx_new;
		end
		if (state_q == S_FOLD && !two_q && !len_q && pend_q) begin
			padw_q <= PAD_BYTE;
			padidx_q <= 4'd0;
		end
		if (state_q == S_PRIME) begin
			a_q <= cv_q[0];
			b_q <= cv_q[1];
			c_q <= cv_q[2];
			d_q <= cv_q[3];
		end
		if (state_q == S_ROUND) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

endmodule
